>>> hdl/gpcm_pkg.sv
// Shared types, constants and decode tables of the grouped PCM unpacker.
package gpcm_pkg;

  // Field and state widths
  localparam int unsigned AccW   = 23;  // chunk accumulator
  localparam int unsigned BitsW  = 5;   // bits collected in a chunk
  localparam int unsigned PosW   = 6;   // run position and output position
  localparam int unsigned LevW   = 6;   // level count
  localparam int unsigned OffW   = 4;   // value offset
  localparam int unsigned ModeW  = 2;   // target mode
  localparam int unsigned ValW   = 7;   // signed output value
  localparam int unsigned GlenW  = 3;   // values in one group, up to 6
  localparam int unsigned CfgW   = 6;   // config write data
  localparam int unsigned CfgIdxW = 2;  // config register index
  localparam int unsigned DivCntW = $clog2(AccW);

  localparam int unsigned MaxValuesDefault = 56;

  // Stream widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned OutUserW = 2;

  // Register reset values
  localparam logic [LevW-1:0]  LevReset  = LevW'(3);
  localparam logic [OffW-1:0]  OffReset  = '0;
  localparam logic [PosW-1:0]  TotReset  = PosW'(1);
  localparam logic [ModeW-1:0] ModeReset = '0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LEVELS = 2'd0,
    REG_OFFSET = 2'd1,
    REG_TOTAL  = 2'd2,
    REG_MODE   = 2'd3
  } reg_e;

  typedef enum logic [ModeW-1:0] {
    MODE_SINGLE = 2'd0,
    MODE_PAIR   = 2'd1,
    MODE_SECOND = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_PUSH,
    S_BAD
  } state_e;

  // Decoded configuration handed to the control path
  typedef struct packed {
    logic [LevW-1:0]  lv;
    logic [OffW-1:0]  offset;
    logic [PosW-1:0]  tot;     // run length clamped to 1..MAX_VALUES
    logic [ModeW-1:0] mode;
    logic [GlenW-1:0] mg;      // group length, zero when unsupported
  } cfg_t;

  // Result of one serial division
  typedef struct packed {
    logic            done;
    logic [AccW-1:0] quotient;
    logic [LevW-1:0] remainder;
  } div_res_t;

  // Values per group for each supported level count
  function automatic logic [GlenW-1:0] group_max(input logic [LevW-1:0] lv);
    logic [GlenW-1:0] g;
    case (lv)
      6'd3:                         g = 3'd5;
      6'd7:                         g = 3'd6;
      6'd11:                        g = 3'd2;
      6'd13, 6'd19, 6'd51:          g = 3'd4;
      6'd25:                        g = 3'd3;
      6'd4, 6'd8, 6'd15, 6'd16,
      6'd26, 6'd31:                 g = 3'd1;
      default:                      g = 3'd0;
    endcase
    return g;
  endfunction

  // Chunk size in bits: ceil(log2(lv**glen))
  function automatic logic [BitsW-1:0] chunk_bits(input logic [LevW-1:0]  lv,
                                                  input logic [GlenW-1:0] glen);
    logic [BitsW-1:0] b;
    b = 5'd0;
    case (lv)
      6'd3: begin
        case (glen)
          3'd1: b = 5'd2;
          3'd2: b = 5'd4;
          3'd3: b = 5'd5;
          3'd4: b = 5'd7;
          3'd5: b = 5'd8;
          default: b = 5'd0;
        endcase
      end
      6'd7: begin
        case (glen)
          3'd1: b = 5'd3;
          3'd2: b = 5'd6;
          3'd3: b = 5'd9;
          3'd4: b = 5'd12;
          3'd5: b = 5'd15;
          3'd6: b = 5'd17;
          default: b = 5'd0;
        endcase
      end
      6'd11: begin
        case (glen)
          3'd1: b = 5'd4;
          3'd2: b = 5'd7;
          default: b = 5'd0;
        endcase
      end
      6'd13: begin
        case (glen)
          3'd1: b = 5'd4;
          3'd2: b = 5'd8;
          3'd3: b = 5'd12;
          3'd4: b = 5'd15;
          default: b = 5'd0;
        endcase
      end
      6'd19: begin
        case (glen)
          3'd1: b = 5'd5;
          3'd2: b = 5'd9;
          3'd3: b = 5'd13;
          3'd4: b = 5'd17;
          default: b = 5'd0;
        endcase
      end
      6'd51: begin
        case (glen)
          3'd1: b = 5'd6;
          3'd2: b = 5'd12;
          3'd3: b = 5'd18;
          3'd4: b = 5'd23;
          default: b = 5'd0;
        endcase
      end
      6'd25: begin
        case (glen)
          3'd1: b = 5'd5;
          3'd2: b = 5'd10;
          3'd3: b = 5'd14;
          default: b = 5'd0;
        endcase
      end
      6'd4:         b = 5'd2;
      6'd8:         b = 5'd3;
      6'd15, 6'd16: b = 5'd4;
      6'd26, 6'd31: b = 5'd5;
      default:      b = 5'd0;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/gpcm_cfg.sv
// Configuration registers and their decode for the grouped PCM unpacker.
module gpcm_cfg
  import gpcm_pkg::*;
#(
  parameter int unsigned MAX_VALUES = MaxValuesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output cfg_t               cfg_o
);

  localparam logic [PosW:0] MaxCmp = (PosW+1)'(MAX_VALUES);

  logic [LevW-1:0]  lv_q;
  logic [OffW-1:0]  off_q;
  logic [PosW-1:0]  tot_q;
  logic [ModeW-1:0] mode_q;
  logic [PosW-1:0]  tot_eff;

  // Write registers by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q   <= LevReset;
      off_q  <= OffReset;
      tot_q  <= TotReset;
      mode_q <= ModeReset;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_LEVELS: lv_q   <= cfg_data_i[LevW-1:0];
        REG_OFFSET: off_q  <= cfg_data_i[OffW-1:0];
        REG_TOTAL:  tot_q  <= cfg_data_i[PosW-1:0];
        REG_MODE:   mode_q <= cfg_data_i[ModeW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp run length to 1..MAX_VALUES
  always_comb begin
    if (tot_q == '0) begin
      tot_eff = PosW'(1);
    end else if ({1'b0, tot_q} > MaxCmp) begin
      tot_eff = MaxCmp[PosW-1:0];
    end else begin
      tot_eff = tot_q;
    end
  end

  assign cfg_o.lv     = lv_q;
  assign cfg_o.offset = off_q;
  assign cfg_o.tot    = tot_eff;
  assign cfg_o.mode   = mode_q;
  assign cfg_o.mg     = group_max(lv_q);

endmodule

>>> hdl/gpcm_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module gpcm_divider
  import gpcm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AccW-1:0] dividend_i,
  input  logic [LevW-1:0] divisor_i,
  output div_res_t        res_o
);

  logic [AccW-1:0]    quo_q;
  logic [LevW-1:0]    rem_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [LevW:0]      trial;
  logic               fits;

  // Trial subtract with the next dividend bit
  assign trial = {rem_q, quo_q[AccW-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DivCntW'(AccW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DivCntW'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Shift dividend out and quotient bits in; hold when idle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[AccW-2:0], fits};
      rem_q <= fits ? LevW'(trial - {1'b0, divisor_i}) : trial[LevW-1:0];
    end
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = quo_q;
  assign res_o.remainder = rem_q;

endmodule

>>> hdl/grouped_pcm_unpack.sv
// Each input item is one bitstream bit; a bit that does not close a chunk leaves input ready.
// A bit that closes a chunk of N values holds input off while the chunk is split: each value
// is one pass of the bit-serial divider plus its start (S_START) and hand-off (S_PUSH) states.
// An unsupported level count yields one flagged result per bit, through the S_BAD state.
// Output items wait in an output register so the next division runs meanwhile.
// Reset (async, active low) clears chunk state and restores register defaults.
module grouped_pcm_unpack
  import gpcm_pkg::*;
#(
  parameter int unsigned MAX_VALUES = MaxValuesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [0] bit_in
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [6:0] value, [7] channel, [13:8] position
  output logic                m_axis_tlast,   // run_last
  output logic [OutUserW-1:0] m_axis_tuser    // [0] group_last, [1] bad_config
);

  cfg_t     cfg;
  div_res_t div_res;
  state_e   state_q, state_d;

  logic [AccW-1:0]  acc_q, pcm_q, acc_nxt;
  logic [BitsW-1:0] bits_q, bits_nxt, size;
  logic [PosW-1:0]  rp_q, rp_eff, room, idx_q;
  logic [PosW:0]    end_sum;
  logic [GlenW-1:0] glen, left_q;
  logic             final_q, is_final, chunk_done;
  logic             s_fire, out_free, div_start;
  logic             take_bit, load_out;

  logic             out_valid_q;
  logic [ValW-1:0]  out_val_q;
  logic             out_ch_q, out_glast_q, out_rlast_q, out_bad_q;
  logic [PosW-1:0]  out_pos_q;
  logic             ch_nxt;
  logic [PosW-1:0]  pos_nxt;

  gpcm_cfg #(
    .MAX_VALUES(MAX_VALUES)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  gpcm_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pcm_q),
    .divisor_i  (cfg.lv),
    .res_o      (div_res)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Group geometry for the incoming bit
  assign rp_eff   = (rp_q >= cfg.tot) ? '0 : rp_q;
  assign room     = cfg.tot - rp_eff;
  assign glen     = (room > PosW'(cfg.mg)) ? cfg.mg : room[GlenW-1:0];
  assign size     = chunk_bits(cfg.lv, glen);
  assign acc_nxt  = {acc_q[AccW-2:0], s_axis_tdata[0]};
  assign bits_nxt = bits_q + BitsW'(1);
  assign chunk_done = bits_nxt >= size;
  assign end_sum  = {1'b0, rp_eff} + (PosW+1)'(glen);
  assign is_final = end_sum >= {1'b0, cfg.tot};

  // Next state and strobes
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    take_bit  = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          take_bit = 1'b1;
          if (cfg.mg == '0) begin
            state_d = S_BAD;
          end else if (chunk_done) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        div_start = 1'b1;
        state_d   = S_WAIT;
      end
      S_WAIT: begin
        if (div_res.done) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = (left_q == GlenW'(1)) ? S_IDLE : S_START;
        end
      end
      S_BAD: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Chunk collection state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      bits_q <= '0;
      rp_q   <= '0;
    end else if (take_bit) begin
      if (cfg.mg == '0) begin
        acc_q  <= '0;
        bits_q <= '0;
        rp_q   <= '0;
      end else if (chunk_done) begin
        acc_q  <= '0;
        bits_q <= '0;
        rp_q   <= is_final ? '0 : end_sum[PosW-1:0];
      end else begin
        acc_q  <= acc_nxt;
        bits_q <= bits_nxt;
        rp_q   <= rp_eff;
      end
    end
  end

  // Digit split bookkeeping: last index first
  always_ff @(posedge clk_i) begin
    if (take_bit && chunk_done) begin
      pcm_q   <= acc_nxt;
      left_q  <= glen;
      idx_q   <= PosW'(end_sum - (PosW+1)'(1));
      final_q <= is_final;
    end else if (load_out && state_q == S_PUSH) begin
      pcm_q  <= div_res.quotient;
      left_q <= left_q - GlenW'(1);
      idx_q  <= idx_q - PosW'(1);
    end
  end

  // Place the value in its destination array
  always_comb begin
    case (mode_e'(cfg.mode))
      MODE_PAIR: begin
        ch_nxt  = idx_q[0];
        pos_nxt = idx_q >> 1;
      end
      MODE_SECOND: begin
        ch_nxt  = 1'b1;
        pos_nxt = idx_q;
      end
      default: begin
        ch_nxt  = 1'b0;
        pos_nxt = idx_q;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (state_q == S_BAD) begin
        out_val_q   <= '0;
        out_ch_q    <= 1'b0;
        out_pos_q   <= '0;
        out_glast_q <= 1'b0;
        out_rlast_q <= 1'b0;
        out_bad_q   <= 1'b1;
      end else begin
        out_val_q   <= ValW'(div_res.remainder) - ValW'(cfg.offset);
        out_ch_q    <= ch_nxt;
        out_pos_q   <= pos_nxt;
        out_glast_q <= (left_q == GlenW'(1));
        out_rlast_q <= (left_q == GlenW'(1)) && final_q;
        out_bad_q   <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_pos_q, out_ch_q, out_val_q};
  assign m_axis_tlast  = out_rlast_q;
  assign m_axis_tuser  = {out_bad_q, out_glast_q};

endmodule

>>> bench/grouped_pcm_unpack_tb.sv
// Self-checking testbench for the grouped PCM unpacker: directed rows, then random runs.
module grouped_pcm_unpack_tb;
  import gpcm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxRun       = MaxValuesDefault;
  localparam int unsigned SettleCycles = 32;
  localparam int unsigned ItemTarget   = 260;
  localparam int unsigned ReportMax    = 10;
  localparam int unsigned SuppLevels [13] = '{3, 4, 7, 8, 11, 13, 15, 16, 19, 25, 26, 31, 51};

  // One decoded value as it leaves the block
  typedef struct packed {
    logic [ValW-1:0] value;
    logic            channel;
    logic [PosW-1:0] position;
    logic            group_last;
    logic            run_last;
    logic            bad_config;
  } pcm_result_t;

  typedef enum logic [1:0] {
    ROW_CFG,       // register write while idle
    ROW_BIT,       // bit checked against the predictor
    ROW_BIT_NONE,  // bit known to give nothing
    ROW_BIT_ONE    // bit known to give the typed result
  } row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    reg_e            reg_sel;
    logic [CfgW-1:0] data;
    logic            b;
    pcm_result_t     want;
  } stim_row_t;

  localparam pcm_result_t NoRes  = '0;
  localparam pcm_result_t BadRes = '{value: '0, channel: 1'b0, position: '0,
                                     group_last: 1'b0, run_last: 1'b0, bad_config: 1'b1};

  localparam int unsigned NumRows = 33;
  stim_row_t dir_rows [NumRows] = '{
    // reset defaults: three levels, one value per run
    '{ROW_BIT_NONE, REG_LEVELS, 6'd0, 1'b1, NoRes},
    '{ROW_BIT_ONE,  REG_LEVELS, 6'd0, 1'b0, '{7'd2, 1'b0, 6'd0, 1'b1, 1'b1, 1'b0}},
    // code 3 is past 3 levels: the high part is dropped
    '{ROW_BIT_NONE, REG_LEVELS, 6'd0, 1'b1, NoRes},
    '{ROW_BIT_ONE,  REG_LEVELS, 6'd0, 1'b1, '{7'd0, 1'b0, 6'd0, 1'b1, 1'b1, 1'b0}},
    // unsupported level counts, extremes among them
    '{ROW_CFG,      REG_LEVELS, 6'd5,  1'b0, NoRes},
    '{ROW_BIT_ONE,  REG_LEVELS, 6'd0,  1'b1, BadRes},
    '{ROW_CFG,      REG_LEVELS, 6'd63, 1'b0, NoRes},
    '{ROW_BIT_ONE,  REG_LEVELS, 6'd0,  1'b0, BadRes},
    '{ROW_CFG,      REG_LEVELS, 6'd0,  1'b0, NoRes},
    '{ROW_BIT_ONE,  REG_LEVELS, 6'd0,  1'b1, BadRes},
    // four levels, largest offset, run length zero, unused target mode
    '{ROW_CFG,      REG_LEVELS, 6'd4,  1'b0, NoRes},
    '{ROW_CFG,      REG_OFFSET, 6'd15, 1'b0, NoRes},
    '{ROW_CFG,      REG_TOTAL,  6'd0,  1'b0, NoRes},
    '{ROW_CFG,      REG_MODE,   6'd3,  1'b0, NoRes},
    '{ROW_BIT_NONE, REG_LEVELS, 6'd0,  1'b0, NoRes},
    '{ROW_BIT_ONE,  REG_LEVELS, 6'd0,  1'b0, '{7'h71, 1'b0, 6'd0, 1'b1, 1'b1, 1'b0}},
    // interleaved pair, two values per run
    '{ROW_CFG,      REG_TOTAL,  6'd2,  1'b0, NoRes},
    '{ROW_CFG,      REG_MODE,   6'(MODE_PAIR), 1'b0, NoRes},
    '{ROW_BIT,      REG_LEVELS, 6'd0,  1'b1, NoRes},
    '{ROW_BIT,      REG_LEVELS, 6'd0,  1'b1, NoRes},
    '{ROW_BIT,      REG_LEVELS, 6'd0,  1'b0, NoRes},
    '{ROW_BIT,      REG_LEVELS, 6'd0,  1'b1, NoRes},
    // second array; then change levels and shrink the run mid-chunk
    '{ROW_CFG,      REG_OFFSET, 6'd0,  1'b0, NoRes},
    '{ROW_CFG,      REG_TOTAL,  6'd3,  1'b0, NoRes},
    '{ROW_CFG,      REG_MODE,   6'(MODE_SECOND), 1'b0, NoRes},
    '{ROW_BIT,      REG_LEVELS, 6'd0,  1'b1, NoRes},
    '{ROW_BIT,      REG_LEVELS, 6'd0,  1'b0, NoRes},
    '{ROW_BIT,      REG_LEVELS, 6'd0,  1'b1, NoRes},
    '{ROW_CFG,      REG_LEVELS, 6'd16, 1'b0, NoRes},
    '{ROW_CFG,      REG_TOTAL,  6'd1,  1'b0, NoRes},
    '{ROW_BIT,      REG_LEVELS, 6'd0,  1'b1, NoRes},
    '{ROW_BIT,      REG_LEVELS, 6'd0,  1'b1, NoRes},
    '{ROW_BIT,      REG_LEVELS, 6'd0,  1'b1, NoRes}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgW-1:0]     cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // [0] bit_in
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [6:0] value, [7] channel, [13:8] position
  logic                m_axis_tlast;        // run_last
  logic [OutUserW-1:0] m_axis_tuser;        // [0] group_last, [1] bad_config

  grouped_pcm_unpack u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor copy of the registers and chunk state
  logic [LevW-1:0]  lv_r;
  logic [OffW-1:0]  off_r;
  logic [PosW-1:0]  tot_r;
  logic [ModeW-1:0] mode_r;
  logic [AccW-1:0]  chunk_acc;
  int unsigned      chunk_bits_seen;
  logic [PosW-1:0]  run_pos;

  pcm_result_t pcm_expected [$];
  int unsigned errors;
  int unsigned bits_sent;

  function automatic int unsigned values_per_group(input logic [LevW-1:0] lv);
    case (lv)
      6'd3:                                      return 5;
      6'd7:                                      return 6;
      6'd11:                                     return 2;
      6'd13, 6'd19, 6'd51:                       return 4;
      6'd25:                                     return 3;
      6'd4, 6'd8, 6'd15, 6'd16, 6'd26, 6'd31:    return 1;
      default:                                   return 0;
    endcase
  endfunction

  // Shift one bit into the chunk; split a complete chunk into values
  task automatic unpack_bit(input logic b, input bit record);
    int unsigned     mg, run_len, glen, nbits, idx, code, digit;
    longint unsigned span;
    logic            run_done;
    pcm_result_t     r;
    mg = values_per_group(lv_r);
    if (mg == 0) begin
      chunk_acc       = '0;
      chunk_bits_seen = 0;
      run_pos         = '0;
      if (record) pcm_expected.push_back(BadRes);
      return;
    end
    run_len = tot_r;
    if (run_len < 1) run_len = 1;
    if (run_len > MaxRun) run_len = MaxRun;
    if (run_pos >= run_len) run_pos = '0;
    glen = run_len - run_pos;
    if (glen > mg) glen = mg;
    span = 1;
    repeat (glen) span = span * lv_r;
    nbits = 0;
    while ((64'd1 << nbits) < span) nbits++;
    chunk_acc = {chunk_acc[AccW-2:0], b};
    chunk_bits_seen++;
    if (chunk_bits_seen < nbits) return;
    run_done = (run_pos + glen) >= run_len;
    code = chunk_acc;
    // Last index comes out first
    for (int unsigned j = 0; j < glen; j++) begin
      idx   = run_pos + glen - 1 - j;
      digit = code % lv_r;
      code  = code / lv_r;
      r            = '0;
      r.value      = ValW'(digit - off_r);
      if (mode_r == MODE_PAIR) begin
        r.channel  = idx[0];
        r.position = PosW'(idx >> 1);
      end else if (mode_r == MODE_SECOND) begin
        r.channel  = 1'b1;
        r.position = PosW'(idx);
      end else begin
        r.channel  = 1'b0;
        r.position = PosW'(idx);
      end
      r.group_last = (j + 1 == glen);
      r.run_last   = r.group_last && run_done;
      if (record) pcm_expected.push_back(r);
    end
    run_pos         = run_done ? '0 : PosW'(run_pos + glen);
    chunk_acc       = '0;
    chunk_bits_seen = 0;
  endtask

  function automatic int unsigned pick_gap(input bit calm);
    if (calm) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // Offer one bit after an optional gap; return once it is taken
  task automatic push_bit(input logic b, input int unsigned gap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-1){1'b0}}, b};
    do @(posedge clk_i); while (!s_axis_tready);
    bits_sent++;
  endtask

  // Hold the sender until every expected value has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pcm_expected.size() != 0);
  endtask

  task automatic drain_idle();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_e sel, input logic [CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    case (sel)
      REG_LEVELS: lv_r   = data[LevW-1:0];
      REG_OFFSET: off_r  = data[OffW-1:0];
      REG_TOTAL:  tot_r  = data[PosW-1:0];
      REG_MODE:   mode_r = data[ModeW-1:0];
      default: ;
    endcase
  endtask

  // Receiver: alternate ready stretches and stalls, mostly short
  int unsigned rdy_left = 0;
  always @(posedge clk_i) begin
    if (rdy_left != 0) begin
      rdy_left <= rdy_left - 1;
    end else if ($urandom_range(0, 2) != 0) begin
      m_axis_tready <= 1'b1;
      rdy_left      <= $urandom_range(0, 30);
    end else begin
      m_axis_tready <= 1'b0;
      rdy_left      <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 3);
    end
  end

  // Compare each value taken from the block with the oldest expectation
  always @(posedge clk_i) begin
    pcm_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.value      = m_axis_tdata[6:0];
      got.channel    = m_axis_tdata[7];
      got.position   = m_axis_tdata[13:8];
      got.group_last = m_axis_tuser[0];
      got.run_last   = m_axis_tlast;
      got.bad_config = m_axis_tuser[1];
      if (pcm_expected.size() == 0) begin
        if (errors < ReportMax)
          $display("unexpected value %0d ch %0d pos %0d glast %0d rlast %0d bad %0d",
                   $signed(got.value), got.channel, got.position, got.group_last,
                   got.run_last, got.bad_config);
        errors++;
      end else begin
        want = pcm_expected.pop_front();
        if (got.value !== want.value || got.channel !== want.channel ||
            got.position !== want.position || got.group_last !== want.group_last ||
            got.run_last !== want.run_last || got.bad_config !== want.bad_config) begin
          if (errors < ReportMax) begin
            $write("mismatch: want val %0d ch %0d pos %0d gl %0d rl %0d bad %0d",
                   $signed(want.value), want.channel, want.position, want.group_last,
                   want.run_last, want.bad_config);
            $display(" / got val %0d ch %0d pos %0d gl %0d rl %0d bad %0d",
                     $signed(got.value), got.channel, got.position, got.group_last,
                     got.run_last, got.bad_config);
          end
          errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned     phase, nbits_phase;
    bit              calm, unsup;
    logic            b;
    logic [LevW-1:0] lv_pick;
    errors          = 0;
    bits_sent       = 0;
    lv_r            = LevReset;
    off_r           = OffReset;
    tot_r           = TotReset;
    mode_r          = ModeReset;
    chunk_acc       = '0;
    chunk_bits_seen = 0;
    run_pos         = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          drain_idle();
          cfg_write(dir_rows[i].reg_sel, dir_rows[i].data);
        end
        ROW_BIT: begin
          push_bit(dir_rows[i].b, pick_gap(1'b0));
          unpack_bit(dir_rows[i].b, 1'b1);
        end
        ROW_BIT_NONE: begin
          push_bit(dir_rows[i].b, pick_gap(1'b0));
          unpack_bit(dir_rows[i].b, 1'b0);
        end
        default: begin
          push_bit(dir_rows[i].b, pick_gap(1'b0));
          unpack_bit(dir_rows[i].b, 1'b0);
          pcm_expected.push_back(dir_rows[i].want);
        end
      endcase
    end

    // Random runs, one register setting per phase
    phase = 0;
    while (bits_sent < ItemTarget) begin
      drain_idle();
      case (phase)
        0: begin
          // widest chunk, largest digit, run length past the maximum
          cfg_write(REG_LEVELS, 6'd51);
          cfg_write(REG_OFFSET, {2'($urandom_range(0, 3)), 4'd0});
          cfg_write(REG_TOTAL, 6'd63);
          cfg_write(REG_MODE, 6'(MODE_SINGLE));
        end
        1: begin
          // longest groups, largest offset, full run, interleaved
          cfg_write(REG_LEVELS, 6'd7);
          cfg_write(REG_OFFSET, 6'd15);
          cfg_write(REG_TOTAL, 6'(MaxRun));
          cfg_write(REG_MODE, 6'(MODE_PAIR));
        end
        default: begin
          if ($urandom_range(0, 7) == 0) lv_pick = LevW'($urandom_range(0, 63));
          else lv_pick = LevW'(SuppLevels[$urandom_range(0, 12)]);
          cfg_write(REG_LEVELS, lv_pick);
          if ($urandom_range(0, 3) != 0) cfg_write(REG_OFFSET, CfgW'($urandom));
          if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
              0:       cfg_write(REG_TOTAL, 6'd0);
              1:       cfg_write(REG_TOTAL, 6'(MaxRun));
              2:       cfg_write(REG_TOTAL, 6'd63);
              default: cfg_write(REG_TOTAL, CfgW'($urandom_range(1, 12)));
            endcase
          end
          if ($urandom_range(0, 3) != 0) cfg_write(REG_MODE, CfgW'($urandom));
        end
      endcase
      unsup       = (values_per_group(lv_r) == 0);
      nbits_phase = unsup ? $urandom_range(3, 8) : $urandom_range(12, 40);
      calm        = ($urandom_range(0, 3) == 0);
      repeat (nbits_phase) begin
        if ($urandom_range(0, 29) == 0) wait_drained();
        b = 1'($urandom);
        push_bit(b, pick_gap(calm));
        unpack_bit(b, 1'b1);
      end
      phase++;
    end

    // Let the last values out, then give the verdict
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0 && pcm_expected.size() == 0) begin
      $display("grouped_pcm_unpack regression: pass");
    end else begin
      $display("grouped_pcm_unpack regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("grouped_pcm_unpack regression: fail");
    $finish;
  end

endmodule

>>> sim.f
hdl/gpcm_pkg.sv
hdl/gpcm_cfg.sv
hdl/gpcm_divider.sv
hdl/grouped_pcm_unpack.sv
bench/grouped_pcm_unpack_tb.sv
